@@ hdl/ede_pkg.sv @@
package ede_pkg;

    // Number of audio channels kept by default.
    localparam int CHANNELS_DEF = 2;

    // Widths of the fixed-point quantities.
    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 24;
    localparam int GAIN_W   = 17;
    localparam int COEF_W   = 16;
    localparam int THR_W    = 25;
    localparam int SLOPE_W  = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 25;
    localparam int MUL_W    = 33;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_ATK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_REL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ATK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_REL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd7;

    // Register reset values.
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 25'd167772;
    localparam logic [THR_W-1:0]   FLOOR_RST     = 25'd16777;
    localparam logic [COEF_W-1:0]  ENV_ATK_RST   = 16'd60000;
    localparam logic [COEF_W-1:0]  ENV_REL_RST   = 16'd65400;
    localparam logic [COEF_W-1:0]  GAIN_ATK_RST  = 16'd62000;
    localparam logic [COEF_W-1:0]  GAIN_REL_RST  = 16'd65400;
    localparam logic [SLOPE_W-1:0] SLOPE_RST     = 17'd32768;

    // Unity gain in Q1.16.
    localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

    // Coefficients of the 2^x polynomial.
    localparam logic [15:0] POLY_C3 = 16'd5178;
    localparam logic [15:0] POLY_C2 = 16'd14752;
    localparam logic [15:0] POLY_C1 = 16'd45599;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV1,
        ST_ENV2,
        ST_CMP,
        ST_DIV,
        ST_LOG,
        ST_SQR,
        ST_EXPM,
        ST_POLYA,
        ST_POLYB,
        ST_POLYC,
        ST_FIN,
        ST_FLOOR,
        ST_GAIN1,
        ST_GAIN2,
        ST_OUTM
    } t_state;

endpackage

@@ hdl/envelope_downward_expander_top.sv @@
// Downward expander for up to two channels of signed 24-bit audio. When enabled, each
// sample beat updates that channel's envelope and smoothed gain and returns the scaled
// sample; when disabled, the sample passes through unchanged. Below threshold the gain
// search uses 16 restoring division steps, 16 squarings for the logarithm, plus polynomial
// and smoothing steps, all on one shared 33x33 multiplier; above threshold only the gain
// smoothing and output scaling run. A zero ratio ends the gain search after the division,
// and a gain that is an exact power of two or that underflows to zero skips the polynomial.
// The final state holds a finished result until the output register is free.
// The input is not ready while a sample is in work; a finished
// result waits in the output register while the next sample is taken. Configuration writes
// are accepted every cycle and must only be made while the block is idle.
module envelope_downward_expander_top #(
    parameter int CHANNELS = ede_pkg::CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_channel,
    input  logic signed [ede_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                              i_block_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_channel_out,
    output logic signed [ede_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                              o_block_last_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ede_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ede_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int MW = ede_pkg::MUL_W;

    ede_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic                          r_enable;
    logic [ede_pkg::THR_W-1:0]     r_thr;
    logic [ede_pkg::THR_W-1:0]     r_floor;
    logic [ede_pkg::COEF_W-1:0]    r_env_atk, r_env_rel, r_gain_atk, r_gain_rel;
    logic [ede_pkg::SLOPE_W-1:0]   r_slope;

    // Per-channel state.
    logic [ede_pkg::LEVEL_W-1:0]   r_env_arr  [CHANNELS];
    logic [ede_pkg::GAIN_W-1:0]    r_gain_arr [CHANNELS];

    // Working registers.
    logic                          r_ch, r_chan_in, r_last;
    logic signed [ede_pkg::SAMPLE_W-1:0] r_x, r_y;
    logic [ede_pkg::LEVEL_W-1:0]   r_lvl, r_env;
    logic [ede_pkg::COEF_W-1:0]    r_coef;
    logic [41:0]                   r_acc;
    logic [ede_pkg::THR_W-1:0]     r_rem;
    logic [15:0]                   r_quo;
    logic [3:0]                    r_cnt;
    logic [3:0]                    r_p;
    logic [31:0]                   r_m;
    logic [15:0]                   r_frac;
    logic [20:0]                   r_e;
    logic [4:0]                    r_q;
    logic [16:0]                   r_g;
    logic [16:0]                   r_t;
    logic [ede_pkg::GAIN_W-1:0]    r_target, r_gain;

    // Output register.
    logic                          r_ovalid, r_ochan, r_olast;
    logic signed [ede_pkg::SAMPLE_W-1:0] r_osample;

    // Shared multiplier.
    logic [MW-1:0]   mul_a, mul_b;
    logic [2*MW-1:0] mul_p;

    ede_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    // Channel select and input level.
    logic                          ch_sel;
    logic                          in_beat;
    logic [ede_pkg::SAMPLE_W-1:0]  abs_x;
    logic [ede_pkg::SAMPLE_W:0]    lvl2;
    logic [ede_pkg::LEVEL_W-1:0]   lvl_sat;

    assign ch_sel  = (32'(i_channel) < CHANNELS) ? i_channel : 1'(CHANNELS - 1);
    assign in_beat = i_valid && o_ready;
    assign abs_x   = i_sample_in[ede_pkg::SAMPLE_W-1] ?
                     ede_pkg::SAMPLE_W'(-i_sample_in) : ede_pkg::SAMPLE_W'(i_sample_in);
    assign lvl2    = {abs_x, 1'b0};
    assign lvl_sat = lvl2[ede_pkg::SAMPLE_W] ? {ede_pkg::LEVEL_W{1'b1}}
                                             : lvl2[ede_pkg::LEVEL_W-1:0];

    // Coefficient choice for the two smoothers.
    logic [ede_pkg::COEF_W-1:0] env_c, gain_c;
    assign env_c  = (r_lvl > r_env) ? r_env_atk : r_env_rel;
    assign gain_c = (r_target > r_gain) ? r_gain_atk : r_gain_rel;

    // Smoother sums.
    logic [41:0] smooth_sum;
    assign smooth_sum = r_acc + mul_p[41:0] + 42'd32768;

    // Division step.
    logic [ede_pkg::THR_W:0] rem2;
    logic                    div_ge;
    assign rem2   = {r_rem, 1'b0};
    assign div_ge = rem2 >= {1'b0, r_thr};

    // Leading one of the quotient.
    logic [3:0] lead;
    always_comb begin
        lead = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (r_quo[i]) begin
                lead = 4'(i);
            end
        end
    end

    // Squaring step.
    logic [31:0] sq;
    assign sq = mul_p[61:30];

    // Logarithm magnitude and exponent split.
    logic [20:0] log_n;
    logic [22:0] e_sum;
    logic [4:0]  e_q;
    logic [15:0] e_f;
    logic [16:0] poly_g;
    assign log_n  = {5'd16 - {1'b0, r_p}, 16'd0} - {5'd0, r_frac};
    assign e_sum  = mul_p[38:16] + 23'd0 + {22'd0, mul_p[15]};
    assign e_q    = r_e[20:16];
    assign e_f    = r_e[15:0];
    assign poly_g = 17'd65536 - {1'b0, e_f};

    // Final 2^x scaling.
    logic [18:0] fin_s;
    logic [18:0] fin_sh;
    assign fin_s  = {2'd0, r_t} + 19'd65536 + (19'd1 << r_q);
    assign fin_sh = fin_s >> (r_q + 5'd1);

    // Gain floor.
    logic [25:0] fl_sum;
    logic [17:0] fl_raw;
    logic [ede_pkg::GAIN_W-1:0] fl;
    assign fl_sum = {1'b0, r_floor} + 26'd128;
    assign fl_raw = fl_sum[25:8];
    assign fl     = (fl_raw > 18'(ede_pkg::UNITY)) ? ede_pkg::UNITY
                                                    : fl_raw[ede_pkg::GAIN_W-1:0];

    // Output scaling with rounding and saturation.
    logic signed [41:0] out_sum;
    logic signed [25:0] out_y;
    logic signed [ede_pkg::SAMPLE_W-1:0] out_sat;
    assign out_sum = $signed(mul_p[41:0]) + 42'sd32768;
    assign out_y   = out_sum[41:16];
    always_comb begin
        priority if (out_y > 26'sd8388607) begin
            out_sat = 24'sh7FFFFF;
        end else if (out_y < -26'sd8388608) begin
            out_sat = -24'sd8388608;
        end else begin
            out_sat = out_y[ede_pkg::SAMPLE_W-1:0];
        end
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ede_pkg::ST_ENV1: begin
                mul_a = MW'(env_c);
                mul_b = MW'(r_env);
            end
            ede_pkg::ST_ENV2: begin
                mul_a = MW'(17'd65536 - {1'b0, r_coef});
                mul_b = MW'(r_lvl);
            end
            ede_pkg::ST_SQR: begin
                mul_a = MW'(r_m);
                mul_b = MW'(r_m);
            end
            ede_pkg::ST_EXPM: begin
                mul_a = MW'(log_n);
                mul_b = MW'(r_slope);
            end
            ede_pkg::ST_POLYA: begin
                mul_a = MW'(ede_pkg::POLY_C3);
                mul_b = MW'(poly_g);
            end
            ede_pkg::ST_POLYB: begin
                mul_a = MW'(17'(ede_pkg::POLY_C2) + r_t);
                mul_b = MW'(r_g);
            end
            ede_pkg::ST_POLYC: begin
                mul_a = MW'(17'(ede_pkg::POLY_C1) + r_t);
                mul_b = MW'(r_g);
            end
            ede_pkg::ST_GAIN1: begin
                mul_a = MW'(gain_c);
                mul_b = MW'(r_gain);
            end
            ede_pkg::ST_GAIN2: begin
                mul_a = MW'(17'd65536 - {1'b0, r_coef});
                mul_b = MW'(r_target);
            end
            ede_pkg::ST_OUTM: begin
                mul_a = {{(MW - ede_pkg::SAMPLE_W){r_x[ede_pkg::SAMPLE_W-1]}}, r_x};
                mul_b = MW'(r_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ede_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = r_enable ? ede_pkg::ST_ENV1 : ede_pkg::ST_FIN;
                end
            end
            ede_pkg::ST_ENV1:  n_state = ede_pkg::ST_ENV2;
            ede_pkg::ST_ENV2:  n_state = ede_pkg::ST_CMP;
            ede_pkg::ST_CMP: begin
                n_state = ({1'b0, r_env} < r_thr) ? ede_pkg::ST_DIV : ede_pkg::ST_GAIN1;
            end
            ede_pkg::ST_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = ede_pkg::ST_LOG;
                end
            end
            ede_pkg::ST_LOG: begin
                n_state = (r_quo == 16'd0) ? ede_pkg::ST_FLOOR : ede_pkg::ST_SQR;
            end
            ede_pkg::ST_SQR: begin
                if (r_cnt == 4'd15) begin
                    n_state = ede_pkg::ST_EXPM;
                end
            end
            ede_pkg::ST_EXPM:  n_state = ede_pkg::ST_POLYA;
            ede_pkg::ST_POLYA: begin
                n_state = (e_q >= 5'd17 || e_f == 16'd0) ? ede_pkg::ST_FLOOR
                                                         : ede_pkg::ST_POLYB;
            end
            ede_pkg::ST_POLYB: n_state = ede_pkg::ST_POLYC;
            ede_pkg::ST_POLYC: n_state = ede_pkg::ST_FIN;
            ede_pkg::ST_FIN: begin
                // In pass-through mode this state only hands the sample to the output.
                if (!r_enable || r_cnt == 4'd15) begin
                    if (!r_ovalid || i_ready) begin
                        n_state = ede_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = ede_pkg::ST_FLOOR;
                end
            end
            ede_pkg::ST_FLOOR: n_state = ede_pkg::ST_GAIN1;
            ede_pkg::ST_GAIN1: n_state = ede_pkg::ST_GAIN2;
            ede_pkg::ST_GAIN2: n_state = ede_pkg::ST_OUTM;
            ede_pkg::ST_OUTM:  n_state = ede_pkg::ST_FIN;
            default:           n_state = ede_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_ready     = (r_state == ede_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
    end

    assign o_valid          = r_ovalid;
    assign o_channel_out    = r_ochan;
    assign o_sample_out     = r_osample;
    assign o_block_last_out = r_olast;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_thr      <= ede_pkg::THRESHOLD_RST;
            r_floor    <= ede_pkg::FLOOR_RST;
            r_env_atk  <= ede_pkg::ENV_ATK_RST;
            r_env_rel  <= ede_pkg::ENV_REL_RST;
            r_gain_atk <= ede_pkg::GAIN_ATK_RST;
            r_gain_rel <= ede_pkg::GAIN_REL_RST;
            r_slope    <= ede_pkg::SLOPE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ede_pkg::REG_ENABLE:    r_enable   <= i_cfg_data[0];
                ede_pkg::REG_THRESHOLD: r_thr      <= i_cfg_data;
                ede_pkg::REG_FLOOR:     r_floor    <= i_cfg_data;
                ede_pkg::REG_ENV_ATK:   r_env_atk  <= i_cfg_data[15:0];
                ede_pkg::REG_ENV_REL:   r_env_rel  <= i_cfg_data[15:0];
                ede_pkg::REG_GAIN_ATK:  r_gain_atk <= i_cfg_data[15:0];
                ede_pkg::REG_GAIN_REL:  r_gain_rel <= i_cfg_data[15:0];
                ede_pkg::REG_SLOPE:     r_slope    <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state and channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ede_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_env_arr[i]  <= '0;
                r_gain_arr[i] <= ede_pkg::UNITY;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ede_pkg::ST_FIN && (!r_enable || r_cnt == 4'd15)
                && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ede_pkg::ST_ENV2) begin
                r_env_arr[r_ch] <= smooth_sum[39:16];
            end
            if (r_state == ede_pkg::ST_GAIN2) begin
                r_gain_arr[r_ch] <= smooth_sum[32:16];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ede_pkg::ST_IDLE: begin
                if (in_beat) begin
                    r_ch      <= ch_sel;
                    r_chan_in <= i_channel;
                    r_last    <= i_block_last;
                    r_x       <= i_sample_in;
                    r_y       <= i_sample_in;
                    r_lvl     <= lvl_sat;
                    r_env     <= r_env_arr[ch_sel];
                    r_gain    <= r_gain_arr[ch_sel];
                    r_target  <= ede_pkg::UNITY;
                    r_cnt     <= 4'd0;
                end
            end
            ede_pkg::ST_ENV1: begin
                r_coef <= env_c;
                r_acc  <= mul_p[41:0];
            end
            ede_pkg::ST_ENV2: begin
                r_env <= smooth_sum[39:16];
            end
            ede_pkg::ST_CMP: begin
                r_rem <= {1'b0, r_env};
                r_cnt <= 4'd0;
            end
            ede_pkg::ST_DIV: begin
                r_rem <= div_ge ? ede_pkg::THR_W'(rem2 - {1'b0, r_thr})
                                : rem2[ede_pkg::THR_W-1:0];
                r_quo <= {r_quo[14:0], div_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            ede_pkg::ST_LOG: begin
                r_target <= '0;
                r_p      <= lead;
                r_m      <= {16'd0, r_quo} << (5'd30 - {1'b0, lead});
                r_frac   <= '0;
                r_cnt    <= 4'd0;
            end
            ede_pkg::ST_SQR: begin
                r_m    <= sq[31] ? {1'b0, sq[31:1]} : sq;
                r_frac <= {r_frac[14:0], sq[31]};
                r_cnt  <= r_cnt + 4'd1;
            end
            ede_pkg::ST_EXPM: begin
                r_e <= e_sum[20:0];
            end
            ede_pkg::ST_POLYA: begin
                r_q <= e_q;
                r_g <= poly_g;
                r_t <= mul_p[32:16];
                r_cnt <= 4'd0;
                if (e_q >= 5'd17) begin
                    r_target <= '0;
                end else begin
                    r_target <= ede_pkg::UNITY >> e_q;
                end
            end
            ede_pkg::ST_POLYB: begin
                r_t <= mul_p[32:16];
            end
            ede_pkg::ST_POLYC: begin
                r_t <= mul_p[32:16];
            end
            ede_pkg::ST_FIN: begin
                // Output hand-off; in the gain path this computes the 2^x result.
                if (!r_enable || r_cnt == 4'd15) begin
                    if (!r_ovalid || i_ready) begin
                        r_ochan   <= r_chan_in;
                        r_olast   <= r_last;
                        r_osample <= r_y;
                    end
                end else begin
                    r_target <= fin_sh[ede_pkg::GAIN_W-1:0];
                end
            end
            ede_pkg::ST_FLOOR: begin
                if (r_target < fl) begin
                    r_target <= fl;
                end
            end
            ede_pkg::ST_GAIN1: begin
                r_coef <= gain_c;
                r_acc  <= mul_p[41:0];
            end
            ede_pkg::ST_GAIN2: begin
                r_gain <= smooth_sum[32:16];
            end
            ede_pkg::ST_OUTM: begin
                r_y   <= out_sat;
                r_cnt <= 4'd15;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/ede_mul.sv @@
// Shared signed multiplier used by the multiplying steps of the sequencer.
module ede_mul (
    input  logic [ede_pkg::MUL_W-1:0]   i_a,
    input  logic [ede_pkg::MUL_W-1:0]   i_b,
    output logic [2*ede_pkg::MUL_W-1:0] o_p
);

    logic signed [2*ede_pkg::MUL_W-1:0] prod;

    // Both operands are two's complement; unsigned values arrive zero-extended.
    assign prod = $signed(i_a) * $signed(i_b);
    assign o_p  = prod;

endmodule
